// ===== design/gda_pkg.sv =====
// Shared types, constants and calendar functions for the Gregorian date adder.
`timescale 1ns / 1ps

package gda_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 16;
  localparam int DeltaW = 16;
  // Working width of day counts and of the year while stepping.
  localparam int AccW   = 17;
  // Width of the year position within the 400-year Gregorian cycle.
  localparam int CycW   = 9;
  // Bits of the shift count in the remainder search.
  localparam int ShW    = 3;

  localparam logic [AccW-1:0]   YearCycleAcc = AccW'(400);
  localparam logic [CycW-1:0]   YearCycleLast = CycW'(399);
  localparam logic [AccW-1:0]   LeapYearLen  = AccW'(366);
  localparam logic [AccW-1:0]   CommonYearLen = AccW'(365);
  localparam logic [MonthW-1:0] MonthFirst   = MonthW'(1);
  localparam logic [MonthW-1:0] MonthLast    = MonthW'(12);
  localparam logic [MonthW-1:0] MonthFeb     = MonthW'(2);
  localparam logic [DayW-1:0]   FebLeapLen   = DayW'(29);
  localparam logic [DayW-1:0]   FebCommonLen = DayW'(28);
  localparam logic [DayW-1:0]   ShortMonthLen = DayW'(30);
  localparam logic [DayW-1:0]   LongMonthLen = DayW'(31);

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic              overflow;
  } res_t;

  // Leap test from the year modulo 400: divisible by 4 but not a century,
  // except that the cycle start (divisible by 400) is a leap year.
  function automatic logic is_leap(input logic [CycW-1:0] r);
    return (r[1:0] == 2'b00) && (r != CycW'(100)) && (r != CycW'(200))
           && (r != CycW'(300));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] n;
    n = LongMonthLen;
    if (m == MonthFeb) begin
      n = leap ? FebLeapLen : FebCommonLen;
    end else if (m inside {MonthW'(4), MonthW'(6), MonthW'(9), MonthW'(11)}) begin
      n = ShortMonthLen;
    end
    return n;
  endfunction

endpackage

// ===== design/gda_seq.sv =====
// Sequencer and shared add/subtract unit that walks a date forward by a day count.
`timescale 1ns / 1ps

module gda_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gda_pkg::DayW-1:0]    in_day,
  input  logic [gda_pkg::MonthW-1:0]  in_month,
  input  logic [gda_pkg::YearW-1:0]   in_year,
  input  logic [gda_pkg::DeltaW-1:0]  in_delta,
  input  logic                        res_ready,
  output logic                        idle,
  output logic                        done,
  output gda_pkg::res_t               res
);

  typedef enum logic [2:0] {
    IDLE,
    MOD,
    CLAMP,
    DOY,
    YEAR,
    MONTH,
    FIN
  } state_t;

  state_t                        st;
  logic [gda_pkg::AccW-1:0]      total;
  logic [gda_pkg::AccW-1:0]      y;
  logic [gda_pkg::CycW-1:0]      r400;
  logic [gda_pkg::MonthW-1:0]    m;
  logic [gda_pkg::MonthW-1:0]    i;
  logic [gda_pkg::ShW-1:0]       k;
  logic [gda_pkg::DayW-1:0]      d;
  logic [gda_pkg::DeltaW-1:0]    delta;

  logic                          leap;
  logic [gda_pkg::DayW-1:0]      mlen;
  logic [gda_pkg::DayW-1:0]      d_min;
  logic [gda_pkg::DayW-1:0]      d_cl;
  logic [gda_pkg::AccW-1:0]      alu_a;
  logic [gda_pkg::AccW-1:0]      alu_b;
  logic                          alu_sub;
  logic [gda_pkg::AccW:0]        alu_res;
  logic                          alu_ge;
  logic                          alu_gt;
  logic [gda_pkg::AccW-1:0]      rem_next;

  assign leap = gda_pkg::is_leap(r400);
  assign mlen = gda_pkg::month_len(m, leap);
  assign d_min = (d == '0) ? gda_pkg::DayW'(1) : d;
  assign d_cl = (d_min > mlen) ? mlen : d_min;

  // The one arithmetic unit for the remainder search and the day counts of every phase.
  always_comb begin
    alu_a   = total;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (st)
      MOD: begin
        alu_b = gda_pkg::YearCycleAcc << k;
      end
      CLAMP: begin
        alu_a   = gda_pkg::AccW'(d_cl);
        alu_b   = gda_pkg::AccW'(delta);
        alu_sub = 1'b0;
      end
      DOY: begin
        alu_b   = gda_pkg::AccW'(gda_pkg::month_len(i, leap));
        alu_sub = 1'b0;
      end
      YEAR: begin
        alu_b = leap ? gda_pkg::LeapYearLen : gda_pkg::CommonYearLen;
      end
      MONTH: begin
        alu_b = gda_pkg::AccW'(mlen);
      end
      default: begin
        alu_b = '0;
      end
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                      : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  assign alu_ge = !alu_res[gda_pkg::AccW];
  assign alu_gt = alu_ge && (alu_res[gda_pkg::AccW-1:0] != '0);
  assign rem_next = alu_ge ? alu_res[gda_pkg::AccW-1:0] : total;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= IDLE;
    end else begin
      case (st)
        IDLE: begin
          if (start) begin
            m     <= (in_month == '0) ? gda_pkg::MonthFirst
                   : (in_month > gda_pkg::MonthLast) ? gda_pkg::MonthLast : in_month;
            y     <= (in_year == '0) ? gda_pkg::AccW'(1) : gda_pkg::AccW'(in_year);
            total <= (in_year == '0) ? gda_pkg::AccW'(1) : gda_pkg::AccW'(in_year);
            d     <= in_day;
            delta <= in_delta;
            k     <= '1;
            st    <= MOD;
          end
        end
        // Restoring remainder of the start year by 400, one shifted divisor a cycle.
        MOD: begin
          total <= rem_next;
          k     <= k - gda_pkg::ShW'(1);
          if (k == '0) begin
            r400 <= rem_next[gda_pkg::CycW-1:0];
            st   <= CLAMP;
          end
        end
        CLAMP: begin
          total <= alu_res[gda_pkg::AccW-1:0];
          i     <= gda_pkg::MonthFirst;
          st    <= DOY;
        end
        DOY: begin
          if (i == m) begin
            st <= YEAR;
          end else begin
            total <= alu_res[gda_pkg::AccW-1:0];
            i     <= i + gda_pkg::MonthW'(1);
          end
        end
        YEAR: begin
          if (alu_gt) begin
            total <= alu_res[gda_pkg::AccW-1:0];
            y     <= y + gda_pkg::AccW'(1);
            r400  <= (r400 == gda_pkg::YearCycleLast) ? '0 : r400 + gda_pkg::CycW'(1);
          end else begin
            m  <= gda_pkg::MonthFirst;
            st <= MONTH;
          end
        end
        MONTH: begin
          if ((m != gda_pkg::MonthLast) && alu_gt) begin
            total <= alu_res[gda_pkg::AccW-1:0];
            m     <= m + gda_pkg::MonthW'(1);
          end else begin
            st <= FIN;
          end
        end
        FIN: begin
          if (res_ready) begin
            st <= IDLE;
          end
        end
        default: begin
          st <= IDLE;
        end
      endcase
    end
  end

  assign idle = (st == IDLE);
  assign done = (st == FIN);
  assign res.day      = total[gda_pkg::DayW-1:0];
  assign res.month    = m;
  assign res.overflow = y[gda_pkg::AccW-1];
  assign res.year     = y[gda_pkg::AccW-1] ? '1 : y[gda_pkg::YearW-1:0];

endmodule

// ===== design/gregorian_date_add_days.sv =====
// Top level of the Gregorian date adder: stream ports and the result register.
//
// Channel  Dir  Fields (tdata, lowest bit first)
// s_axis   in   start_day[4:0] start_month[8:5] start_year[24:9] delta_days[40:25]
// m_axis   out  new_day[4:0] new_month[8:5] new_year[24:9] year_overflow[25]
//
// An item steps from acceptance through MOD, CLAMP, DOY, YEAR and MONTH to FIN
// and then into the result register, with a YEAR step for each year crossed (at
// most about 180), DOY steps up to the start month and MONTH steps for the months
// passed. All day arithmetic runs through the single add/subtract unit in gda_seq.
// Reset is synchronous and clears the sequencer and the output valid flag.
// The next item is accepted while a finished result waits in the output register.
`timescale 1ns / 1ps

module gregorian_date_add_days (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_day[4:0], start_month[8:5], start_year[24:9], delta_days[40:25], zero fill
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // new_day[4:0], new_month[8:5], new_year[24:9], year_overflow[25], zero fill
  output logic [31:0] m_axis_tdata
);

  logic          idle;
  logic          done;
  logic          res_ready;
  gda_pkg::res_t res;
  gda_pkg::res_t out_res;

  assign s_axis_tready = idle;
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  gda_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (s_axis_tvalid && idle),
    .in_day    (s_axis_tdata[4:0]),
    .in_month  (s_axis_tdata[8:5]),
    .in_year   (s_axis_tdata[24:9]),
    .in_delta  (s_axis_tdata[40:25]),
    .res_ready (res_ready),
    .idle      (idle),
    .done      (done),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done && res_ready) begin
      m_axis_tvalid <= 1'b1;
      out_res       <= res;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {6'b0, out_res.overflow, out_res.year, out_res.month, out_res.day};

endmodule

// ===== tb/sv/gregorian_date_add_days_checker.sv =====
// Checker for the date adder: predicts each result from the accepted items and compares.
`timescale 1ns / 1ps

module gregorian_date_add_days_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // start_day[4:0], start_month[8:5], start_year[24:9], delta_days[40:25], zero fill
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // new_day[4:0], new_month[8:5], new_year[24:9], year_overflow[25], zero fill
  input  logic [31:0] m_axis_tdata,
  output int          errors,
  output int          pending
);

  gda_pkg::res_t expected_dates[$];

  function automatic bit leap_yr(input int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int days_of_month(input int m, input int y);
    int n;
    case (m)
      2:           n = leap_yr(y) ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default:     n = 31;
    endcase
    return n;
  endfunction

  function automatic gda_pkg::res_t date_after(input logic [gda_pkg::DayW-1:0] d_in,
                                               input logic [gda_pkg::MonthW-1:0] m_in,
                                               input logic [gda_pkg::YearW-1:0] y_in,
                                               input logic [gda_pkg::DeltaW-1:0] delta);
    int d, m, y, doy, ylen, mlen;
    gda_pkg::res_t r;
    m = (m_in < 1) ? 1 : ((m_in > 12) ? 12 : int'(m_in));
    y = (y_in == 0) ? 1 : int'(y_in);
    d = (d_in == 0) ? 1 : int'(d_in);
    mlen = days_of_month(m, y);
    if (d > mlen) d = mlen;
    doy = d;
    for (int i = 1; i < m; i++) doy += days_of_month(i, y);
    doy += delta;
    // Whole years go by with the leap rule of each year passed through.
    ylen = leap_yr(y) ? 366 : 365;
    while (doy > ylen) begin
      doy -= ylen;
      y++;
      ylen = leap_yr(y) ? 366 : 365;
    end
    m = 1;
    while (m < 12) begin
      mlen = days_of_month(m, y);
      if (doy <= mlen) break;
      doy -= mlen;
      m++;
    end
    r.day      = doy[gda_pkg::DayW-1:0];
    r.month    = m[gda_pkg::MonthW-1:0];
    r.overflow = (y > 65535);
    r.year     = r.overflow ? {gda_pkg::YearW{1'b1}} : y[gda_pkg::YearW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    gda_pkg::res_t want;
    logic [gda_pkg::DayW-1:0]   got_day;
    logic [gda_pkg::MonthW-1:0] got_month;
    logic [gda_pkg::YearW-1:0]  got_year;
    logic                       got_ovf;
    int                         bad;
    bad = 0;
    if (rst) begin
      errors  <= 0;
      pending <= 0;
      expected_dates.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dates.push_back(date_after(s_axis_tdata[4:0], s_axis_tdata[8:5],
                                            s_axis_tdata[24:9], s_axis_tdata[40:25]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_day   = m_axis_tdata[4:0];
        got_month = m_axis_tdata[8:5];
        got_year  = m_axis_tdata[24:9];
        got_ovf   = m_axis_tdata[25];
        if (expected_dates.size() == 0) begin
          $error("result with no item waiting: day %0d month %0d year %0d overflow %0d",
                 got_day, got_month, got_year, got_ovf);
          bad++;
        end else begin
          want = expected_dates.pop_front();
          if (got_day !== want.day) begin
            $error("new_day: expected %0d, actual %0d", want.day, got_day);
            bad++;
          end
          if (got_month !== want.month) begin
            $error("new_month: expected %0d, actual %0d", want.month, got_month);
            bad++;
          end
          if (got_year !== want.year) begin
            $error("new_year: expected %0d, actual %0d", want.year, got_year);
            bad++;
          end
          if (got_ovf !== want.overflow) begin
            $error("year_overflow: expected %0d, actual %0d", want.overflow, got_ovf);
            bad++;
          end
        end
      end
      errors  <= errors + bad;
      pending <= expected_dates.size();
    end
  end

endmodule

// ===== tb/sv/gregorian_date_add_days_tb.sv =====
// Top of the date adder testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module gregorian_date_add_days_tb;

  localparam int RandomItems = 1600;
  localparam int IdleLimit   = 12000;
  localparam int HoldCycles  = 1500;
  localparam int DrainCycles = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  int errors;
  int pending;
  int results_done;
  int idle_cycles;
  int items_sent;
  bit sender_quiet;

  always #2 clk = ~clk;

  gregorian_date_add_days dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gregorian_date_add_days_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending)
  );

  // Stall watchdog: any cycle without a handshake on either side counts.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles  <= 0;
      results_done <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) results_done <= results_done + 1;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("gregorian_date_add_days: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the block backs up, and a
  // stretch with tready held high.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && results_done >= 100) begin
        hold_left = HoldCycles;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else if (results_done >= 900 && results_done < 1200) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= 9);
      end
      @(negedge clk);
    end
  end

  task automatic send_date(input logic [4:0] d, input logic [3:0] m,
                           input logic [15:0] y, input logic [15:0] delta);
    while (!sender_quiet && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'b0, delta, y, m, d};
    // Ready only moves at rising edges, so its value here holds for the next edge.
    while (!s_axis_tready) @(negedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  initial begin
    logic [4:0]  d;
    logic [3:0]  m;
    logic [15:0] y;
    logic [15:0] delta;
    int pick;
    items_sent   = 0;
    sender_quiet = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, clamping of bad dates, leap rules, year end
    // and year overflow.
    send_date(5'd1, 4'd1, 16'd1, 16'd0);
    send_date(5'd31, 4'd12, 16'd65535, 16'd65535);
    send_date(5'd0, 4'd0, 16'd0, 16'd0);
    send_date(5'd31, 4'd15, 16'd2023, 16'd0);
    send_date(5'd31, 4'd13, 16'd2023, 16'd40);
    send_date(5'd30, 4'd2, 16'd2024, 16'd0);
    send_date(5'd29, 4'd2, 16'd1900, 16'd0);
    send_date(5'd29, 4'd2, 16'd2000, 16'd0);
    send_date(5'd31, 4'd2, 16'd2100, 16'd0);
    send_date(5'd31, 4'd4, 16'd2023, 16'd0);
    send_date(5'd30, 4'd12, 16'd2023, 16'd1);
    send_date(5'd31, 4'd12, 16'd2023, 16'd1);
    send_date(5'd31, 4'd12, 16'd2024, 16'd0);
    send_date(5'd1, 4'd1, 16'd2024, 16'd365);
    send_date(5'd1, 4'd1, 16'd2023, 16'd365);
    send_date(5'd28, 4'd2, 16'd2024, 16'd1);
    send_date(5'd28, 4'd2, 16'd2023, 16'd1);
    send_date(5'd31, 4'd12, 16'd65535, 16'd1);
    send_date(5'd1, 4'd1, 16'd65535, 16'd364);
    send_date(5'd1, 4'd3, 16'd1899, 16'd65535);
    send_date(5'd15, 4'd6, 16'd1999, 16'd400);
    send_date(5'd17, 4'd8, 16'd40000, 16'd12345);

    for (int i = 0; i < RandomItems; i++) begin
      sender_quiet = (i >= 400 && i < 700);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        d = 5'($urandom_range(1, 31));
        m = 4'($urandom_range(1, 12));
      end else begin
        d = 5'($urandom_range(0, 31));
        m = 4'($urandom_range(0, 15));
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        y = 16'($urandom_range(1, 65535));
      end else if (pick < 80) begin
        y = 16'($urandom_range(65300, 65535));
      end else if (pick < 95) begin
        // At or just before a century, so the step can cross the century rule.
        y = 16'($urandom_range(1, 654) * 100 - $urandom_range(0, 3));
      end else begin
        y = 16'($urandom_range(0, 65535));
      end
      delta = ($urandom_range(0, 99) < 60) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 800));
      send_date(d, m, y, delta);
    end
    s_axis_tvalid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("gregorian_date_add_days: match");
    end else begin
      $display("gregorian_date_add_days: mismatch");
    end
    $finish;
  end

endmodule

// ===== gregorian_date_add_days.f =====
design/gda_pkg.sv
design/gda_seq.sv
design/gregorian_date_add_days.sv
tb/sv/gregorian_date_add_days_checker.sv
tb/sv/gregorian_date_add_days_tb.sv
